/* rtl/core/point_in_polygon_crossing_defines.svh */
// assertion macros for the point in polygon crossing block
// used by modules that check their own control logic, needs clk and rst in scope
`ifndef POINT_IN_POLYGON_CROSSING_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_DEFINES_SVH

// same-cycle implication
`define PIPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipc assertion failed");

// next-cycle implication
`define PIPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipc assertion failed");

`endif

/* rtl/core/pipc_pkg.sv */
// shared types and codes for the point in polygon crossing block
// no dependencies
package pipc_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [6:0] CROSS_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } pipc_req_t;

  typedef struct packed {
    logic [6:0] crossings;
    logic       inside_res;
    logic       overflowed;
  } pipc_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WRAP,
    S_DRAIN,
    S_DONE
  } pipc_state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic query;
    logic rd_en;
    logic wrap;
    logic out_load;
  } pipc_cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
    logic busy;
    logic out_full;
  } pipc_sts_t;

endpackage

/* rtl/core/pipc_ctrl.sv */
// controller state machine: accepts words, sequences the edge walk, loads results
// depends on pipc_pkg and point_in_polygon_crossing_defines.svh
`include "point_in_polygon_crossing_defines.svh"

module pipc_ctrl
  import pipc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_func,
  output logic       req_stall,
  input  pipc_sts_t  st,
  output pipc_cmd_t  cmd
);

  pipc_state_t state, state_next;
  logic        accept;

  assign accept = req_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req_func == FUNC_QUERY) begin
          state_next = st.empty ? S_DRAIN : S_READ;
        end
      end
      S_READ: begin
        if (st.rd_last) begin
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!st.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall  = 1'b0;
        cmd.clear  = accept && req_func == FUNC_CLEAR;
        cmd.append = accept && req_func == FUNC_APPEND;
        cmd.query  = accept && req_func == FUNC_QUERY;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        cmd.out_load = !st.out_full;
      end
      default: begin
      end
    endcase
  end

  `PIPC_ASSERT_IMP(a_wrap_after_read, cmd.wrap, $past(cmd.rd_en))
  `PIPC_ASSERT_IMP(a_read_nonempty, cmd.rd_en, !st.empty)
  `PIPC_ASSERT_IMP(a_load_free, cmd.out_load, !st.out_full)
  `PIPC_ASSERT_NXT(a_load_fills, cmd.out_load, st.out_full)

endmodule

/* rtl/core/pipc_dp.sv */
// datapath: vertex memory, edge pipeline with cross-multiply test, count and result register
// depends on pipc_pkg
module pipc_dp
  import pipc_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  pipc_req_t req_word,
  input  pipc_cmd_t cmd,
  output pipc_sts_t st,
  output logic      res_valid,
  input  logic      res_stall,
  output pipc_res_t res_word
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SW    = (CNT_W > 7) ? CNT_W : 7;

  function automatic logic signed [CW-1:0] to_coord(input logic [15:0] raw);
    logic [CW+15:0] ext;
    ext = {{CW{1'b0}}, raw};
    return signed'(ext[CW-1:0]);
  endfunction

  logic [2*CW-1:0]   mem [MAX_VERTICES];
  logic [CNT_W-1:0]  vcount;
  logic              overflow;
  logic [AW-1:0]     rd_idx;
  logic [CNT_W-1:0]  rd_idx_inc;
  logic signed [CW-1:0] px, py;

  logic [2*CW-1:0]   rd_q;
  logic              a0_v, a0_first, a0_wrap;
  logic [2*CW-1:0]   v0, prev;

  logic [2*CW-1:0]   cur;
  logic              edge_v, swap, in_range;
  logic signed [CW-1:0] ax, ay, bx, by, x0, y0, x1, y1;

  logic              b_v;
  logic signed [DW-1:0] b_dx, b_dpy, b_dpx, b_dy;
  logic              c_v;
  logic signed [PW-1:0] c_lhs, c_rhs;

  logic [CNT_W-1:0]  acc;
  logic [SW-1:0]     acc_w;

  // vertex store and count
  always_ff @(posedge clk) begin
    if (cmd.append && vcount < CNT_W'(MAX_VERTICES)) begin
      mem[vcount[AW-1:0]] <= {to_coord(req_word.coord_x), to_coord(req_word.coord_y)};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= '0;
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      vcount   <= '0;
      overflow <= 1'b0;
    end else if (cmd.append) begin
      if (vcount < CNT_W'(MAX_VERTICES)) begin
        vcount <= vcount + CNT_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      rd_idx <= '0;
      px     <= to_coord(req_word.coord_x);
      py     <= to_coord(req_word.coord_y);
    end else if (cmd.rd_en) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  assign rd_idx_inc = CNT_W'(rd_idx) + CNT_W'(1);

  // read stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      a0_v    <= 1'b0;
      a0_wrap <= 1'b0;
    end else begin
      a0_v    <= cmd.rd_en;
      a0_wrap <= cmd.wrap;
    end
    a0_first <= (rd_idx == '0);
    if (a0_v) begin
      prev <= rd_q;
      if (a0_first) begin
        v0 <= rd_q;
      end
    end
  end

  // edge setup: order by y, range test, differences
  always_comb begin
    cur      = a0_wrap ? v0 : rd_q;
    edge_v   = (a0_v && !a0_first) || a0_wrap;
    ax       = signed'(prev[2*CW-1:CW]);
    ay       = signed'(prev[CW-1:0]);
    bx       = signed'(cur[2*CW-1:CW]);
    by       = signed'(cur[CW-1:0]);
    swap     = ay > by;
    x0       = swap ? bx : ax;
    y0       = swap ? by : ay;
    x1       = swap ? ax : bx;
    y1       = swap ? ay : by;
    in_range = (py >= y0) && (py < y1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      b_v <= edge_v && in_range;
      c_v <= b_v;
    end
    b_dx  <= DW'(x1) - DW'(x0);
    b_dpy <= DW'(py) - DW'(y0);
    b_dpx <= DW'(px) - DW'(x0);
    b_dy  <= DW'(y1) - DW'(y0);
    c_lhs <= PW'(b_dx) * PW'(b_dpy);
    c_rhs <= PW'(b_dpx) * PW'(b_dy);
  end

  // crossing count
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      acc <= '0;
    end else if (c_v && c_lhs > c_rhs) begin
      acc <= acc + CNT_W'(1);
    end
  end

  assign acc_w = SW'(acc);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      res_word.crossings  <= (acc_w > SW'(CROSS_MAX)) ? CROSS_MAX : acc_w[6:0];
      res_word.inside_res <= acc[0];
      res_word.overflowed <= overflow;
    end
  end

  assign st.empty    = (vcount == '0);
  assign st.rd_last  = (rd_idx_inc == vcount);
  assign st.busy     = a0_v || a0_wrap || b_v || c_v;
  assign st.out_full = res_valid;

endmodule

/* rtl/core/point_in_polygon_crossing.sv */
// top level of the ray-casting point in polygon block
// instantiates pipc_ctrl and pipc_dp, types from pipc_pkg
//
//   channel  dir  handshake        word
//   req      in   valid / stall    func, coord_x, coord_y
//   res      out  valid / stall    crossings, inside_res, overflowed
//
// clear and append are taken directly in the idle state; a query reads the stored vertices
// and walks the edges, one edge per cycle from the single read port of the vertex memory,
// then the wrap edge, setup, two-stage multiply drain and result load; req stalls meanwhile.
// rst is synchronous; it empties the polygon and drops any pending result.
// a held result does not block clear or append words; a query waits at its end
// until the result register is free.
module point_in_polygon_crossing
  import pipc_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  pipc_req_t req_word,
  output logic      res_valid,
  input  logic      res_stall,
  output pipc_res_t res_word
);

  pipc_cmd_t cmd;
  pipc_sts_t st;

  pipc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req_word.func),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  pipc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
